>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the encoder decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is active.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/renc_pkg.sv
// Shared types, constants and the code-to-phase map of the rotary encoder decoder.
// No dependencies.
package renc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int HOLD_WIDTH      = 17;
    localparam int LEVEL_WIDTH     = 6;
    localparam int HOLD_CFG_WIDTH  = 16;

    localparam logic [LEVEL_WIDTH-1:0]    LEVEL_MAX = 6'd50;
    localparam logic [LEVEL_WIDTH-1:0]    LEVEL_ON  = 6'd37;
    localparam logic [LEVEL_WIDTH-1:0]    LEVEL_OFF = 6'd12;
    localparam logic [HOLD_WIDTH-1:0]     HOLD_MAX  = '1;
    localparam logic [HOLD_CFG_WIDTH-1:0] HOLD_TICKS_RESET = 16'd1000;

    localparam logic [2:0] PHASE_UNKNOWN = 3'd0;
    localparam logic [2:0] PHASE_FIRST   = 3'd1;
    localparam logic [2:0] PHASE_LAST    = 3'd4;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_DETENT = 2'd1,
        EVT_PRESS  = 2'd2,
        EVT_HOLD   = 2'd3
    } event_kind_t;

    localparam logic signed [1:0] DIR_ZERO = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    typedef struct packed {
        logic hold_fire;
        logic press_event;
    } btn_evt_t;

    typedef struct packed {
        logic up;
        logic down;
    } knob_evt_t;

    // Gray order: code 0 -> 1, 1 -> 2, 3 -> 3, 2 -> 4
    function automatic logic [2:0] phase_of_code(input logic [1:0] code);
        logic [2:0] ph;
        case (code)
            2'b00:   ph = 3'd1;
            2'b01:   ph = 3'd2;
            2'b11:   ph = 3'd3;
            2'b10:   ph = 3'd4;
            default: ph = 3'd1;
        endcase
        return ph;
    endfunction

endpackage

>>> hdl/renc_button.sv
// Button integrator with hysteresis and the long-hold counter.
// Depends on renc_pkg.
module renc_button import renc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      pressed,
    input  logic [HOLD_CFG_WIDTH-1:0] long_hold_ticks,
    output btn_evt_t                  evt
);

    logic [HOLD_WIDTH-1:0]  hold_reg, hold_next, hold_inc;
    logic [LEVEL_WIDTH-1:0] level_reg, level_next;
    logic                   latched_reg, latched_next;

    always_comb begin
        if (pressed) begin
            hold_inc   = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
            level_next = (level_reg == LEVEL_MAX) ? level_reg : level_reg + 1'b1;
        end else begin
            hold_inc   = '0;
            level_next = (level_reg == '0) ? level_reg : level_reg - 1'b1;
        end

        evt.hold_fire   = hold_inc > {1'b0, long_hold_ticks};
        hold_next       = evt.hold_fire ? '0 : hold_inc;

        evt.press_event = (level_next > LEVEL_ON) && !latched_reg;
        if (level_next > LEVEL_ON) begin
            latched_next = 1'b1;
        end else if (level_next < LEVEL_OFF) begin
            latched_next = 1'b0;
        end else begin
            latched_next = latched_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg    <= '0;
            level_reg   <= '0;
            latched_reg <= 1'b0;
        end else if (advance) begin
            hold_reg    <= hold_next;
            level_reg   <= level_next;
            latched_reg <= latched_next;
        end
    end

endmodule

>>> hdl/renc_knob.sv
// Quadrature phase tracker, step counter and detent detection.
// Depends on renc_pkg.
module renc_knob import renc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic [1:0] code,
    input  logic      detent_ok,
    output knob_evt_t evt
);

    logic [2:0]             phase_reg, phase_next;
    logic [2:0]             up_phase, down_phase, target;
    logic [COUNT_WIDTH-1:0] step_reg, step_next;
    logic [COUNT_WIDTH-1:0] reported_reg, reported_next;
    logic [COUNT_WIDTH-1:0] diff;

    always_comb begin
        up_phase   = {1'b0, phase_reg[1:0]} + 3'd1;
        down_phase = {1'b0, phase_reg[1:0] + 2'd2} + 3'd1;
        target     = phase_of_code(code);
        phase_next = phase_reg;
        step_next  = step_reg;
        if (phase_reg >= PHASE_FIRST && phase_reg <= PHASE_LAST) begin
            if (target == up_phase) begin
                phase_next = up_phase;
                step_next  = step_reg + 1'b1;
            end else if (target == down_phase) begin
                phase_next = down_phase;
                step_next  = step_reg - 1'b1;
            end
        end else begin
            // unknown phase: adopt the current code without counting
            phase_next = target;
        end

        diff     = step_next - reported_reg;
        evt.up   = !diff[COUNT_WIDTH-1] && (diff > COUNT_WIDTH'(3));
        evt.down = diff[COUNT_WIDTH-1] && ((~diff) > COUNT_WIDTH'(2));

        reported_next = reported_reg;
        if (detent_ok && evt.up) begin
            reported_next = reported_reg + COUNT_WIDTH'(4);
        end else if (detent_ok && evt.down) begin
            reported_next = reported_reg - COUNT_WIDTH'(4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_UNKNOWN;
            step_reg     <= '0;
            reported_reg <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            reported_reg <= reported_next;
        end
    end

endmodule

>>> hdl/rotary_encoder_button_decoder.sv
// Top level of the rotary encoder and button decoder: input register,
// event priority, result register. Depends on renc_pkg, renc_button, renc_knob.
//
// Each input item is one sampling tick of the active-low pins A, B and button;
// each item yields exactly one result item (event kind and direction). The block
// takes one item per clock: a sample is held in the input register, all state
// (quadrature phase, step and reported counts, integrator, hold counter) is
// updated by a single combinational pass, and the result lands in the output
// register with that state once it is free or being taken. A stalled
// result holds the pipe; the input side stays ready while the input register is
// empty or the output register is free or being taken.
// The long-hold threshold is written through cfg_wr_en/cfg_wr_data (reset 1000).
module rotary_encoder_button_decoder import renc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [HOLD_CFG_WIDTH-1:0] cfg_wr_data,   // long_hold_ticks
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,       // [0] pin_a, [1] pin_b, [2] button_pin
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,       // [1:0] direction
    output logic [1:0]                m_tuser        // [1:0] event_kind
);

    logic [HOLD_CFG_WIDTH-1:0] long_hold_reg;
    logic                      in_valid_reg;
    logic [2:0]                pins_reg;
    logic                      m_valid_reg;
    event_kind_t               kind_reg, kind_next;
    logic signed [1:0]         dir_reg, dir_next;
    logic                      out_free, advance;
    btn_evt_t                  btn_evt;
    knob_evt_t                 knob_evt;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    renc_button u_button (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .pressed         (!pins_reg[2]),
        .long_hold_ticks (long_hold_reg),
        .evt             (btn_evt)
    );

    renc_knob #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_knob (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .code      ({!pins_reg[1], !pins_reg[0]}),
        .detent_ok (!btn_evt.hold_fire && !btn_evt.press_event),
        .evt       (knob_evt)
    );

    // long hold beats press, press beats detent
    always_comb begin
        kind_next = EVT_NONE;
        dir_next  = DIR_ZERO;
        if (btn_evt.hold_fire) begin
            kind_next = EVT_HOLD;
        end else if (btn_evt.press_event) begin
            kind_next = EVT_PRESS;
        end else if (knob_evt.up) begin
            kind_next = EVT_DETENT;
            dir_next  = DIR_UP;
        end else if (knob_evt.down) begin
            kind_next = EVT_DETENT;
            dir_next  = DIR_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_hold_reg <= HOLD_TICKS_RESET;
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                long_hold_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= s_tdata[2:0];
        end
        if (advance) begin
            kind_reg <= kind_next;
            dir_reg  <= dir_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, dir_reg};
    assign m_tuser  = kind_reg;

endmodule

>>> hdl/renc_checker.sv
// Port-level checker for the rotary encoder decoder, bound to the top level.
// Depends on renc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module renc_checker import renc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `ASSERT_CLK_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `ASSERT_CLK(a_stall_holds, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled item changed")

    `ASSERT_CLK(a_detent_dir, aclk, aresetn,
        m_tvalid && m_tuser == EVT_DETENT |-> m_tdata[1:0] == DIR_UP || m_tdata[1:0] == DIR_DOWN,
        "detent without direction")

    `ASSERT_CLK(a_other_no_dir, aclk, aresetn,
        m_tvalid && m_tuser != EVT_DETENT |-> m_tdata[1:0] == DIR_ZERO,
        "direction on non-detent item")

    `ASSERT_CLK(a_press_single, aclk, aresetn,
        m_tvalid && m_tready && m_tuser == EVT_PRESS |=> !(m_tvalid && m_tuser == EVT_PRESS),
        "press reported twice in a row")

endmodule

bind rotary_encoder_button_decoder renc_checker u_renc_checker (.*);

>>> tb/rotary_encoder_button_decoder_tb.sv
// Self-checking testbench for rotary_encoder_button_decoder: quadrature steps, detents,
// button integrator, press and long-hold events, checked against an in-bench decoder.
// Depends on renc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module rotary_encoder_button_decoder_tb;
    import renc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [5:0]  LEVEL_TOP      = 6'd50;
    localparam logic [5:0]  LEVEL_SET      = 6'd37;
    localparam logic [5:0]  LEVEL_CLEAR    = 6'd12;
    localparam logic [16:0] HOLD_TOP       = 17'h1FFFF;
    localparam logic [15:0] DETENT_STEPS   = 16'd4;
    localparam logic [1:0]  DIR_NONE_V     = 2'b00;
    localparam logic [1:0]  DIR_CW_V       = 2'b01;
    localparam logic [1:0]  DIR_CCW_V      = 2'b11;
    localparam int          MOVE_JUMP      = 2;

    typedef struct packed {
        event_kind_t kind;
        logic [1:0]  dir;
    } decoded_evt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // decoder state mirrored in the bench
    logic [2:0]  knob_ph;
    logic [15:0] step_cnt;
    logic [15:0] rep_cnt;
    logic [16:0] hold_cnt;
    logic [5:0]  level;
    logic        latched;
    logic [15:0] hold_limit;

    decoded_evt_t pending_events[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int n_detent = 0;
    int n_press = 0;
    int n_hold = 0;
    int quiet_cycles = 0;

    // stimulus-side knob position (Gray index 0..3) and button level
    int   knob_idx = 0;
    int   knob_dir = 1;
    logic btn_level = 1'b1;
    int   btn_left = 0;

    rotary_encoder_button_decoder u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic decoded_evt_t decode_tick(input logic a, input logic b,
                                                 input logic btn);
        logic [1:0]   code;
        logic         press_now;
        logic [2:0]   target;
        logic [2:0]   up_ph;
        logic [2:0]   dn_ph;
        logic [15:0]  diff;
        decoded_evt_t r;
        code = {~b, ~a};
        press_now = 1'b0;
        r.kind = EVT_NONE;
        r.dir = DIR_NONE_V;

        if (!btn) begin
            if (hold_cnt != HOLD_TOP) hold_cnt = hold_cnt + 17'd1;
            if (level < LEVEL_TOP) level = level + 6'd1;
        end else begin
            hold_cnt = 17'd0;
            if (level != 6'd0) level = level - 6'd1;
        end
        if (level > LEVEL_SET) begin
            if (!latched) begin
                press_now = 1'b1;
                latched = 1'b1;
            end
        end else if (level < LEVEL_CLEAR) begin
            latched = 1'b0;
        end

        case (code)
            2'b00:   target = 3'd1;
            2'b01:   target = 3'd2;
            2'b11:   target = 3'd3;
            default: target = 3'd4;
        endcase
        if (knob_ph >= 3'd1 && knob_ph <= 3'd4) begin
            up_ph = {1'b0, knob_ph[1:0]} + 3'd1;
            dn_ph = {1'b0, knob_ph[1:0] + 2'd2} + 3'd1;
            if (target == up_ph) begin
                step_cnt = step_cnt + 16'd1;
                knob_ph = up_ph;
            end else if (target == dn_ph) begin
                step_cnt = step_cnt - 16'd1;
                knob_ph = dn_ph;
            end
        end else begin
            knob_ph = target;
        end

        // long hold wins, then press, then detent; losers are dropped this tick
        diff = step_cnt - rep_cnt;
        if (hold_cnt > {1'b0, hold_limit}) begin
            r.kind = EVT_HOLD;
            hold_cnt = 17'd0;
        end else if (press_now) begin
            r.kind = EVT_PRESS;
        end else if (!diff[15] && diff >= DETENT_STEPS) begin
            r.kind = EVT_DETENT;
            r.dir = DIR_CW_V;
            rep_cnt = rep_cnt + DETENT_STEPS;
        end else if (diff[15] && diff <= (16'd0 - DETENT_STEPS)) begin
            r.kind = EVT_DETENT;
            r.dir = DIR_CCW_V;
            rep_cnt = rep_cnt - DETENT_STEPS;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(input logic a, input logic b, input logic btn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, btn, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_events.push_back(decode_tick(a, b, btn));
        items_sent++;
        @(negedge aclk);
    endtask

    // Move the knob by one Gray step (+1/-1), stay (0) or jump two, then send.
    task automatic send_knob(input int move, input logic btn);
        logic [1:0] code;
        knob_idx = (knob_idx + move) & 3;
        case (knob_idx)
            0:       code = 2'b00;
            1:       code = 2'b01;
            2:       code = 2'b11;
            default: code = 2'b10;
        endcase
        send_tick(~code[0], ~code[1], btn);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_hold_limit(input logic [15:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        hold_limit = v;
        @(negedge aclk);
    endtask

    task automatic test_knob_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_hold_limit(16'd1000);
        knob_idx = 1;
        send_knob(0, 1'b1);        // unknown phase adopts this code
        repeat (4) send_knob(1, 1'b1);
        send_knob(0, 1'b1);
        send_knob(MOVE_JUMP, 1'b1); // jump of two: ignored
        send_knob(MOVE_JUMP, 1'b1);
        repeat (4) send_knob(-1, 1'b1);
        repeat (3) send_knob(-1, 1'b1);
        send_knob(1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        drain_results();
    endtask

    task automatic test_press_directed();
        send_idle_pct = 26;
        recv_stall_pct = 26;
        repeat (34) send_knob(0, 1'b0);
        // the press fires on the last of these four steps, which complete no detent
        repeat (4) send_knob(1, 1'b0);
        repeat (14) send_knob(0, 1'b0);
        repeat (30) send_knob(0, 1'b1);
        repeat (34) send_knob(0, 1'b0);
        repeat (4) send_knob(-1, 1'b0);
        repeat (4) send_knob(0, 1'b0);
        repeat (60) send_knob(0, 1'b1);
        drain_results();
    endtask

    task automatic test_long_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_hold_limit(16'd0);      // fires on every pressed tick, press is lost
        repeat (45) send_knob(0, 1'b0);
        repeat (50) send_knob(0, 1'b1);
        drain_results();
        set_hold_limit(16'd5);
        repeat (20) send_knob(0, 1'b0);
        repeat (40) send_knob(0, 1'b1);
        drain_results();
        set_hold_limit(16'd100);    // fires once the hold passes the threshold
        repeat (110) send_knob(0, 1'b0);
        repeat (40) send_knob(0, 1'b1);
        drain_results();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n_items,
                               input logic [15:0] limit);
        int r;
        drain_results();
        set_hold_limit(limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            if (btn_left == 0) begin
                btn_level = ~btn_level;
                btn_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                       : $urandom_range(5, 90);
            end
            btn_left--;
            if ($urandom_range(0, 99) < 10) knob_dir = -knob_dir;
            r = $urandom_range(0, 99);
            if (r < 55)      send_knob(knob_dir, btn_level);
            else if (r < 75) send_knob(0, btn_level);
            else if (r < 87) send_knob(MOVE_JUMP, btn_level);
            else             send_knob($urandom_range(0, 3), btn_level);
        end
        drain_results();
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        decoded_evt_t exp_evt;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind=%0d data=%02h",
                                          m_tuser, m_tdata));
            end else begin
                exp_evt = pending_events.pop_front();
                if (m_tuser !== exp_evt.kind)
                    report_mismatch($sformatf("result %0d: event_kind %0d, want %0d",
                                              results_seen, m_tuser, exp_evt.kind));
                if (m_tdata !== {6'd0, exp_evt.dir})
                    report_mismatch($sformatf("result %0d: tdata %02h, want %02h",
                                              results_seen, m_tdata, {6'd0, exp_evt.dir}));
                case (exp_evt.kind)
                    EVT_DETENT: n_detent++;
                    EVT_PRESS:  n_press++;
                    EVT_HOLD:   n_hold++;
                    default:    ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        knob_ph = 3'd0;
        step_cnt = 16'd0;
        rep_cnt = 16'd0;
        hold_cnt = 17'd0;
        level = 6'd0;
        latched = 1'b0;
        hold_limit = 16'd1000;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_knob_directed();
        test_press_directed();
        test_long_hold();
        test_random(0, 0, 135, 16'd40);
        test_random(61, 0, 135, 16'd0);
        test_random(0, 61, 135, 16'hFFFF);
        test_random(26, 26, 136, 16'($urandom_range(0, 200)));

        repeat (10) @(posedge aclk);
        $display("Sent %0d pin samples under four idle/stall mixes and several hold thresholds.",
                 items_sent);
        $display("Checked %0d results: %0d detents, %0d presses, %0d long holds.",
                 results_seen, n_detent, n_press, n_hold);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
